// ===== hdl/sare_pkg.sv =====
package sare_pkg;

    // Command codes carried by an input item.
    typedef enum logic [1:0] {
        CMD_SEND = 2'd0,
        CMD_RECV = 2'd1,
        CMD_ACK  = 2'd2,
        CMD_TICK = 2'd3
    } t_cmd;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_SEND_OK  = 3'd0,
        KIND_SEND_FULL = 3'd1,
        KIND_DELIVER  = 3'd2,
        KIND_DROP     = 3'd3,
        KIND_RETX     = 3'd4,
        KIND_ACK_OUT  = 3'd5,
        KIND_ACK_DONE = 3'd6
    } t_kind;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_ROLE         = 2'd0,
        CFG_ACK_INTERVAL = 2'd1,
        CFG_SPARE2       = 2'd2,
        CFG_SPARE3       = 2'd3
    } t_cfg_idx;

    localparam logic        ROLE_CLIENT      = 1'b0;
    localparam logic        ROLE_SERVER      = 1'b1;
    localparam logic [15:0] ACK_INTERVAL_RST = 16'd1000;
    localparam logic [31:0] SEQ_NONE         = 32'hFFFF_FFFF;
    localparam logic [15:0] TICK_MAX         = 16'hFFFF;

    typedef struct packed {
        t_cmd        cmd;
        logic        reliable;
        logic [15:0] buffer_handle;
        logic [31:0] seq_in;
    } t_in;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] seq_out;
        logic [15:0] handle_out;
        logic [5:0]  freed_count;
        logic        disconnect_flag;
        logic        last;
    } t_out;

    // Handshake between the front queue and the back engine.
    typedef struct packed {
        logic valid;
        t_in  item;
    } t_q_head;

    // Back engine states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_RTX_RD,
        ST_RTX_OUT
    } t_state;

endpackage

// ===== hdl/sare_ram.sv =====
module sare_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/sare_front.sv =====
module sare_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  sare_pkg::t_in    i_item,
    output logic             o_busy,
    output sare_pkg::t_q_head o_head,
    input  logic             i_pop
);
    import sare_pkg::*;

    t_in        r_slot [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       push;
    logic       pop;

    // A transaction is taken whenever the queue has a free slot.
    assign o_busy = (r_count == 2'd2);
    assign push   = i_start && !o_busy;
    assign pop    = i_pop && (r_count != 2'd0);

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_slot[r_rd_ptr];

    // Pointer and fill count bookkeeping.
    always_comb begin
        n_wr_ptr = push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end
endmodule

// ===== hdl/sare_back.sv =====
module sare_back #(
    parameter int DEPTH        = 32,
    parameter int HANDLE_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_role,
    input  logic [15:0]       i_ack_interval,
    input  sare_pkg::t_q_head i_head,
    output logic              o_pop,
    output logic              o_res_strobe,
    output sare_pkg::t_out    o_res
);
    import sare_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int UW = $clog2(DEPTH + 1);
    localparam int RW = 32 + HANDLE_WIDTH;

    t_state            r_state, n_state;
    logic [31:0]       r_send_cnt, n_send_cnt;
    logic [31:0]       r_recv_cnt, n_recv_cnt;
    logic [PW-1:0]     r_tail, n_tail;
    logic [PW-1:0]     r_head, n_head;
    logic [UW-1:0]     r_used, n_used;
    logic [15:0]       r_tick, n_tick;
    logic              r_ovf, n_ovf;
    logic [31:0]       r_ack_seq, n_ack_seq;
    logic [UW-1:0]     r_freed, n_freed;
    logic [PW-1:0]     r_idx, n_idx;
    logic [UW-1:0]     r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;

    logic              ram_we;
    logic [PW-1:0]     ram_raddr;
    logic [RW-1:0]     ram_rdata;
    logic [31:0]       rd_seq;
    logic [HANDLE_WIDTH-1:0] rd_handle;
    logic [HANDLE_WIDTH-1:0] in_handle;
    logic [15:0]       tick_inc;
    logic              take;
    logic              tail_wrap;
    logic              head_wrap;
    logic              idx_wrap;
    t_out              final_res;

    sare_ram #(
        .WIDTH(RW),
        .DEPTH(DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_head),
        .i_wdata({r_send_cnt, in_handle}),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign rd_seq    = ram_rdata[RW-1:HANDLE_WIDTH];
    assign rd_handle = ram_rdata[HANDLE_WIDTH-1:0];
    assign in_handle = HANDLE_WIDTH'(i_head.item.buffer_handle);
    assign tick_inc  = (r_tick < TICK_MAX) ? r_tick + 16'd1 : r_tick;
    assign take      = (r_state == ST_IDLE) && i_head.valid;
    assign tail_wrap = (r_tail == PW'(DEPTH - 1));
    assign head_wrap = (r_head == PW'(DEPTH - 1));
    assign idx_wrap  = (r_idx == PW'(DEPTH - 1));

    // Closing result of an ack transaction.
    always_comb begin
        final_res.kind            = (i_role == ROLE_SERVER) ? KIND_ACK_OUT : KIND_ACK_DONE;
        final_res.seq_out         = (i_role == ROLE_SERVER) ? r_recv_cnt : r_ack_seq;
        final_res.handle_out      = 16'd0;
        final_res.freed_count     = 6'(r_freed);
        final_res.disconnect_flag = r_ovf;
        final_res.last            = 1'b1;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (take && i_head.item.cmd == CMD_ACK) begin
                    n_state = ST_FREE_RD;
                end
            end
            ST_FREE_RD: begin
                n_state = (r_used == '0) ? ST_IDLE : ST_FREE_CHK;
            end
            ST_FREE_CHK: begin
                n_state = (rd_seq < r_ack_seq) ? ST_FREE_RD : ST_RTX_RD;
            end
            ST_RTX_RD: begin
                n_state = (r_cnt == r_used) ? ST_IDLE : ST_RTX_OUT;
            end
            ST_RTX_OUT: begin
                n_state = ST_RTX_RD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and results.
    always_comb begin
        n_send_cnt  = r_send_cnt;
        n_recv_cnt  = r_recv_cnt;
        n_tail      = r_tail;
        n_head      = r_head;
        n_used      = r_used;
        n_tick      = r_tick;
        n_ovf       = r_ovf;
        n_ack_seq   = r_ack_seq;
        n_freed     = r_freed;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_out_valid = 1'b0;
        n_out       = r_out;
        o_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_raddr   = r_tail;

        unique case (r_state)
            ST_IDLE: begin
                if (take) begin
                    o_pop                 = 1'b1;
                    n_out.handle_out      = 16'd0;
                    n_out.freed_count     = 6'd0;
                    n_out.disconnect_flag = r_ovf;
                    n_out.last            = 1'b1;
                    unique case (i_head.item.cmd)
                        CMD_SEND: begin
                            n_out_valid      = 1'b1;
                            n_out.handle_out = 16'(in_handle);
                            n_out.kind       = KIND_SEND_OK;
                            if (!i_head.item.reliable) begin
                                n_out.seq_out = SEQ_NONE;
                            end else begin
                                n_send_cnt    = r_send_cnt + 32'd1;
                                n_out.seq_out = r_send_cnt;
                                if (r_used >= UW'(DEPTH)) begin
                                    n_ovf                 = 1'b1;
                                    n_out.kind            = KIND_SEND_FULL;
                                    n_out.disconnect_flag = 1'b1;
                                end else begin
                                    ram_we = 1'b1;
                                    n_head = head_wrap ? '0 : r_head + PW'(1);
                                    n_used = r_used + UW'(1);
                                end
                            end
                        end
                        CMD_RECV: begin
                            n_out_valid = 1'b1;
                            if (i_head.item.seq_in == SEQ_NONE) begin
                                n_out.kind    = KIND_DELIVER;
                                n_out.seq_out = SEQ_NONE;
                            end else if (i_head.item.seq_in > r_recv_cnt) begin
                                if (i_role == ROLE_CLIENT) begin
                                    n_tick = 16'd0;
                                end
                                n_out.kind    = KIND_ACK_OUT;
                                n_out.seq_out = r_recv_cnt;
                            end else if (i_head.item.seq_in < r_recv_cnt) begin
                                n_out.kind    = KIND_DROP;
                                n_out.seq_out = i_head.item.seq_in;
                            end else begin
                                n_recv_cnt    = r_recv_cnt + 32'd1;
                                n_out.kind    = KIND_DELIVER;
                                n_out.seq_out = i_head.item.seq_in;
                            end
                        end
                        CMD_ACK: begin
                            n_ack_seq = i_head.item.seq_in;
                            n_freed   = '0;
                        end
                        CMD_TICK: begin
                            if (i_role == ROLE_CLIENT) begin
                                n_tick = tick_inc;
                                if (tick_inc > i_ack_interval) begin
                                    n_tick        = 16'd0;
                                    n_out_valid   = 1'b1;
                                    n_out.kind    = KIND_ACK_OUT;
                                    n_out.seq_out = r_recv_cnt;
                                end
                            end
                        end
                        default: begin
                            n_out_valid = 1'b0;
                        end
                    endcase
                end
            end
            ST_FREE_RD: begin
                // Look at the oldest entry, or finish once the ring is empty.
                if (r_used == '0) begin
                    n_tail      = '0;
                    n_head      = '0;
                    n_out_valid = 1'b1;
                    n_out       = final_res;
                end
            end
            ST_FREE_CHK: begin
                if (rd_seq < r_ack_seq) begin
                    n_tail  = tail_wrap ? '0 : r_tail + PW'(1);
                    n_used  = r_used - UW'(1);
                    n_freed = r_freed + UW'(1);
                end else begin
                    n_idx = r_tail;
                    n_cnt = '0;
                end
            end
            ST_RTX_RD: begin
                ram_raddr = r_idx;
                if (r_cnt == r_used) begin
                    n_out_valid = 1'b1;
                    n_out       = final_res;
                end
            end
            ST_RTX_OUT: begin
                // Retransmit the entry read in the previous cycle.
                n_out_valid           = 1'b1;
                n_out.kind            = KIND_RETX;
                n_out.seq_out         = rd_seq;
                n_out.handle_out      = 16'(rd_handle);
                n_out.freed_count     = 6'd0;
                n_out.disconnect_flag = r_ovf;
                n_out.last            = 1'b0;
                n_idx = idx_wrap ? '0 : r_idx + PW'(1);
                n_cnt = r_cnt + UW'(1);
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_send_cnt  <= '0;
            r_recv_cnt  <= '0;
            r_tail      <= '0;
            r_head      <= '0;
            r_used      <= '0;
            r_tick      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_send_cnt  <= n_send_cnt;
            r_recv_cnt  <= n_recv_cnt;
            r_tail      <= n_tail;
            r_head      <= n_head;
            r_used      <= n_used;
            r_tick      <= n_tick;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers and the result register need no reset.
    always_ff @(posedge i_clk) begin
        r_ack_seq <= n_ack_seq;
        r_freed   <= n_freed;
        r_idx     <= n_idx;
        r_cnt     <= n_cnt;
        r_out     <= n_out;
    end

    assign o_res_strobe = r_out_valid;
    assign o_res        = r_out;
endmodule

// ===== hdl/seq_ack_retransmit_engine.sv =====
// Send and receive transactions give one result each, a tick one only for a
// client past its ack interval. Ack transactions: take, free the oldest
// entries while their sequence is below the ack, retransmit each entry left,
// then close (an emptied ring closes right after the last free). Results are
// registered. A two-entry queue takes new transactions while the engine works;
// busy is high only when it is full. The receiver cannot hold results off.
module seq_ack_retransmit_engine #(
    parameter int DEPTH        = 32,
    parameter int HANDLE_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  sare_pkg::t_in    i_item,
    output logic             o_res_strobe,
    output sare_pkg::t_out   o_res,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data
);
    import sare_pkg::*;

    logic        r_role;
    logic [15:0] r_ack_interval;
    t_q_head     q_head;
    logic        q_pop;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_role         <= ROLE_CLIENT;
            r_ack_interval <= ACK_INTERVAL_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ROLE:         r_role <= i_cfg_data[0];
                CFG_ACK_INTERVAL: r_ack_interval <= i_cfg_data;
                CFG_SPARE2, CFG_SPARE3: begin
                end
                default: begin
                end
            endcase
        end
    end

    sare_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_item (i_item),
        .o_busy (busy),
        .o_head (q_head),
        .i_pop  (q_pop)
    );

    sare_back #(
        .DEPTH       (DEPTH),
        .HANDLE_WIDTH(HANDLE_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_role        (r_role),
        .i_ack_interval(r_ack_interval),
        .i_head        (q_head),
        .o_pop         (q_pop),
        .o_res_strobe  (o_res_strobe),
        .o_res         (o_res)
    );
endmodule

// ===== hdl/sare_checker.sv =====
module sare_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_res_strobe,
    input sare_pkg::t_out o_res
);
    import sare_pkg::*;

    logic r_disc_seen;

    // Track whether a disconnect has been reported since reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disc_seen <= 1'b0;
        end else if (o_res_strobe && o_res.disconnect_flag) begin
            r_disc_seen <= 1'b1;
        end
    end

    // No result comes out right after reset.
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_strobe)
        else $error("result strobe right after reset");

    // The disconnect flag never falls once reported.
    a_disc_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && r_disc_seen) |-> o_res.disconnect_flag)
        else $error("disconnect flag dropped");

    // Freed count appears only on a closing ack result.
    a_freed_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.freed_count != 6'd0) |->
        (o_res.last && (o_res.kind == KIND_ACK_OUT || o_res.kind == KIND_ACK_DONE)))
        else $error("freed count on wrong result");

    // Retransmits are never the last result of a transaction.
    a_retx_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.kind == KIND_RETX) |-> !o_res.last)
        else $error("retransmit marked last");

    // Handles only ride on send and retransmit results.
    a_handle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.handle_out != 16'd0) |->
        (o_res.kind == KIND_SEND_OK || o_res.kind == KIND_SEND_FULL
         || o_res.kind == KIND_RETX))
        else $error("handle on non-send result");
endmodule

bind seq_ack_retransmit_engine sare_checker u_sare_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_res_strobe(o_res_strobe),
    .o_res       (o_res)
);
